// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the console RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tcc_pkg.sv =====
// Types and constants of the text console cursor engine
package tcc_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] ATTR_RESET = 8'd7;

    // ring holds a full pending buffer plus one full buffer still being drained
    localparam int STORE_DEPTH = 128;
    localparam int PTR_W       = 7;
    localparam int CNT_W       = 7;
    localparam int CMDQ_DEPTH  = 2;
    localparam int OUT_DEPTH   = 4;

    localparam logic CMD_DRAIN = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic        cell_write;
        logic [10:0] cell_address;
        logic [15:0] cell_data;
        logic        scroll_up;
        logic        clear_all;
        logic [10:0] cursor_position;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic             kind;
        logic [CNT_W-1:0] count;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [15:0]      data;
    } ram_wr_t;

endpackage

// ===== hdl/tcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module tcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/tcc_front.sv =====
// Front end: takes requests, buffers cells in the ring and issues drain/clear commands
`include "assert_macros.svh"

module tcc_front
    import tcc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  item,
    output logic      full,
    input  logic      cfg_valid,
    input  logic [7:0] cfg_data,
    output ram_wr_t   ram_wr,
    output logic      cmd_push,
    output cmd_t      cmd,
    input  logic      cmd_full,
    input  logic      cell_freed
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W:0]   used_reg, used_next;
    logic [7:0]       attr_reg;
    logic             accept;

    assign full   = (used_reg == (PTR_W+1)'(STORE_DEPTH)) || cmd_full;
    assign accept = push && !full;

    always_comb
    begin
        count_next   = count_reg;
        ram_wr.en    = 1'b0;
        ram_wr.addr  = wr_ptr_reg;
        ram_wr.data  = {attr_reg, item.char_code};
        cmd_push     = 1'b0;
        cmd.kind     = CMD_DRAIN;
        cmd.count    = count_reg;
        if (accept)
        begin
            unique case (item.func)
                FUNC_WRITE:
                begin
                    ram_wr.en = 1'b1;
                    if (count_reg < CNT_W'(BUFFER_DEPTH))
                    begin
                        if (item.char_code == CH_NEWLINE)
                        begin
                            cmd_push   = 1'b1;
                            cmd.count  = count_reg + 1'b1;
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_push   = 1'b1;
                        count_next = CNT_W'(1);
                    end
                end
                FUNC_FLUSH:
                begin
                    cmd_push   = (count_reg != '0);
                    count_next = '0;
                end
                FUNC_CLEAR:
                begin
                    cmd_push = 1'b1;
                    cmd.kind = CMD_CLEAR;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign used_next = used_reg + (PTR_W+1)'(ram_wr.en) - (PTR_W+1)'(cell_freed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            used_reg   <= '0;
            attr_reg   <= ATTR_RESET;
        end
        else
        begin
            count_reg <= count_next;
            used_reg  <= used_next;
            if (ram_wr.en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    `ASSERT_ALWAYS(a_ring_bound, clk, rst_n, used_reg <= (PTR_W+1)'(STORE_DEPTH), "ring overflow")
    `ASSERT_IMPLIES(a_pending_in_ring, clk, rst_n, count_reg != '0, (PTR_W+1)'(count_reg) <= used_reg, "buffered cells missing from ring")

endmodule

// ===== hdl/tcc_cmd_fifo.sv =====
// Short command queue between front and back ends
module tcc_cmd_fifo
    import tcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic empty
);

    localparam int AW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          q_reg [CMDQ_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full   = (cnt_reg == CW'(CMDQ_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_cmd = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

// ===== hdl/tcc_back.sv =====
// Back end: reads drained cells, tracks the cursor and queues results
`include "assert_macros.svh"

module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    output logic             ram_rd,
    output logic [PTR_W-1:0] ram_addr,
    input  logic [15:0]      ram_data,
    output logic             empty,
    input  logic             pop,
    output out_item_t        result
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int PH_W   = $clog2(TAB_STEP);
    localparam int NC_W   = $clog2(COLUMNS + TAB_STEP);
    localparam int POS_W  = $clog2(ROWS * COLUMNS + 1);
    localparam int OA_W   = $clog2(OUT_DEPTH);
    localparam int OC_W   = $clog2(OUT_DEPTH + 1);
    localparam logic [POS_W-1:0] LAST_ROW_POS = POS_W'((ROWS - 1) * COLUMNS);

    logic             active_reg, active_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_clear_reg, s1_clear_next;
    logic             s1_last_reg, s1_last_next;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    out_item_t        oq_reg [OUT_DEPTH];
    logic [OA_W-1:0]  oq_wr_reg, oq_rd_reg;
    logic [OC_W-1:0]  oq_cnt_reg;
    logic             issue_ok;
    logic             oq_pop;
    out_item_t        res;

    logic [NC_W-1:0]  tab_col;
    logic             wrap_row;
    logic [7:0]       ch;

    assign issue_ok = (oq_cnt_reg + OC_W'(s1_valid_reg)) < OC_W'(OUT_DEPTH);
    assign ram_addr = rd_ptr_reg;

    always_comb
    begin
        cmd_pop       = 1'b0;
        ram_rd        = 1'b0;
        active_next   = active_reg;
        remain_next   = remain_reg;
        s1_valid_next = 1'b0;
        s1_clear_next = 1'b0;
        s1_last_next  = 1'b0;
        if (issue_ok)
        begin
            if (active_reg)
            begin
                ram_rd        = 1'b1;
                s1_valid_next = 1'b1;
                s1_last_next  = (remain_reg == CNT_W'(1));
                remain_next   = remain_reg - 1'b1;
                active_next   = (remain_reg != CNT_W'(1));
            end
            else if (!cmd_empty)
            begin
                cmd_pop = 1'b1;
                if (cmd.kind == CMD_CLEAR)
                begin
                    s1_valid_next = 1'b1;
                    s1_clear_next = 1'b1;
                    s1_last_next  = 1'b1;
                end
                else
                begin
                    active_next = 1'b1;
                    remain_next = cmd.count;
                end
            end
        end
    end

    // cell placement
    assign ch      = ram_data[7:0];
    assign tab_col = NC_W'(col_reg) - NC_W'(phase_reg) + NC_W'(TAB_STEP);

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        wrap_row   = 1'b0;
        res        = '0;
        if (s1_clear_reg)
        begin
            row_next      = '0;
            col_next      = '0;
            phase_next    = '0;
            pos_next      = '0;
            res.clear_all = 1'b1;
        end
        else
        begin
            if (ch == CH_NEWLINE)
            begin
                wrap_row = 1'b1;
            end
            else if (ch == CH_TAB)
            begin
                if (tab_col >= NC_W'(COLUMNS))
                begin
                    wrap_row = 1'b1;
                end
                else
                begin
                    col_next   = COL_W'(tab_col);
                    phase_next = '0;
                    pos_next   = pos_reg + POS_W'(TAB_STEP) - POS_W'(phase_reg);
                end
            end
            else
            begin
                res.cell_write   = 1'b1;
                res.cell_address = 11'(pos_reg);
                res.cell_data    = ram_data;
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    wrap_row = 1'b1;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    phase_next = (phase_reg == PH_W'(TAB_STEP - 1)) ? '0 : phase_reg + 1'b1;
                    pos_next   = pos_reg + 1'b1;
                end
            end
            if (wrap_row)
            begin
                col_next   = '0;
                phase_next = '0;
                if (row_reg == ROW_W'(ROWS - 1))
                begin
                    res.scroll_up = 1'b1;
                    pos_next      = LAST_ROW_POS;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    pos_next = pos_reg - POS_W'(col_reg) + POS_W'(COLUMNS);
                end
            end
        end
        res.cursor_position = 11'(pos_next);
        res.last            = s1_last_reg;
    end

    // result queue
    assign empty  = (oq_cnt_reg == '0);
    assign result = oq_reg[oq_rd_reg];
    assign oq_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            remain_reg   <= '0;
            rd_ptr_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s1_clear_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            phase_reg    <= '0;
            pos_reg      <= '0;
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_cnt_reg   <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            remain_reg   <= remain_next;
            s1_valid_reg <= s1_valid_next;
            s1_clear_reg <= s1_clear_next;
            s1_last_reg  <= s1_last_next;
            if (ram_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (s1_valid_reg)
            begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                oq_wr_reg <= (oq_wr_reg == OA_W'(OUT_DEPTH - 1)) ? '0 : oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= (oq_rd_reg == OA_W'(OUT_DEPTH - 1)) ? '0 : oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + OC_W'(s1_valid_reg) - OC_W'(oq_pop);
        end
    end

    `ASSERT_ALWAYS(a_oq_bound, clk, rst_n, oq_cnt_reg <= OC_W'(OUT_DEPTH), "result queue overflow")
    `ASSERT_IMPLIES(a_active_remain, clk, rst_n, active_reg, remain_reg != '0, "drain active with nothing left")
    `ASSERT_NEXT(a_last_ends_drain, clk, rst_n, ram_rd && s1_last_next, !active_reg, "drain continues past last cell")

endmodule

// ===== hdl/text_console_cursor_engine_core.sv =====
// Top level of the buffered text console cursor engine
//
// Request channel: item (func, char_code) is taken when push is high and
// full is low. Writes are buffered with the current attribute and give no
// result until a newline, a write to a full buffer, or a flush drains them.
// Clear screen gives a single result and leaves the buffer as it is.
// Attribute register: cfg_data is written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Write it only while the block is idle.
// Result channel: the oldest result sits on result while empty is low and
// leaves on a clock edge with pop high. last marks the final result of a
// request. A drain passes the command queue, ring read and result queue;
// then one cell per cycle while the result queue has room, set by the single
// read port of the 128-entry cell ring. Buffering takes one request a cycle
// until full, which rises when the ring holds 128 cells or the command queue
// is full; a stalled result side fills the four-entry result queue and stops
// the back end, then the ring and command queue, then the request side.
// Reset empties the buffer, homes the cursor and sets the attribute to 7.
module text_console_cursor_engine_core
    import tcc_pkg::*;
#(
    parameter int COLUMNS      = 80,
    parameter int ROWS         = 25,
    parameter int TAB_STEP     = 8,
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  in_item_t   item,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    ram_wr_t          ram_wr;
    logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t             cmd_in, cmd_out;
    logic             ram_rd;
    logic [PTR_W-1:0] ram_rd_addr;
    logic [15:0]      ram_rd_data;

    assign cfg_ready = 1'b1;

    tcc_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .ram_wr    (ram_wr),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full),
        .cell_freed(ram_rd)
    );

    tcc_ram #(
        .WIDTH(16),
        .DEPTH(STORE_DEPTH)
    ) u_ring (
        .clk    (clk),
        .wr_en  (ram_wr.en),
        .wr_addr(ram_wr.addr),
        .wr_data(ram_wr.data),
        .rd_en  (ram_rd),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    tcc_cmd_fifo u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cmd_push),
        .wr_cmd(cmd_in),
        .full  (cmd_full),
        .rd_en (cmd_pop),
        .rd_cmd(cmd_out),
        .empty (cmd_empty)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .TAB_STEP(TAB_STEP)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .ram_rd   (ram_rd),
        .ram_addr (ram_rd_addr),
        .ram_data (ram_rd_data),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== verif/tb_text_console_cursor_engine_core.sv =====
// Testbench for text_console_cursor_engine_core: random traffic against a cursor predictor
module tb_text_console_cursor_engine_core;
    import tcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int TAB_STEP      = 8;
    localparam int BUFFER_DEPTH  = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 50;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef enum {
        SEQ_LINE,
        SEQ_LONG,
        SEQ_FLUSHED,
        SEQ_CLEAR,
        SEQ_NOISE,
        SEQ_RAW,
        SEQ_SCREEN
    } seq_kind_t;

    class console_cell_checker;
        logic [15:0] cell_buffer [BUFFER_DEPTH];
        int          buffered;
        int          row;
        int          col;
        logic [7:0]  attribute;
        out_item_t   due_results [$];
        int          errors;
        int          checked;

        function new();
            buffered  = 0;
            row       = 0;
            col       = 0;
            attribute = ATTR_RESET;
            errors    = 0;
            checked   = 0;
        endfunction

        function void place_cell(logic [15:0] cell_word);
            out_item_t r;
            int        next_col;
            r = '0;
            if (cell_word[7:0] == CH_NEWLINE)
            begin
                row++;
                col = 0;
            end
            else if (cell_word[7:0] == CH_TAB)
            begin
                next_col = (col / TAB_STEP + 1) * TAB_STEP;
                if (next_col >= COLUMNS)
                begin
                    col = 0;
                    row++;
                end
                else
                begin
                    col = next_col;
                end
            end
            else
            begin
                r.cell_write   = 1'b1;
                r.cell_address = 11'(row * COLUMNS + col);
                r.cell_data    = cell_word;
                col++;
                if (col >= COLUMNS)
                begin
                    row++;
                    col = 0;
                end
            end
            if (row >= ROWS)
            begin
                r.scroll_up = 1'b1;
                row = ROWS - 1;
                col = 0;
            end
            r.cursor_position = 11'(row * COLUMNS + col);
            due_results.push_back(r);
        endfunction

        function void drain_buffer();
            for (int i = 0; i < buffered; i++)
                place_cell(cell_buffer[i]);
            buffered = 0;
        endfunction

        function void buffer_char(logic [7:0] ch);
            if (buffered < BUFFER_DEPTH)
                cell_buffer[buffered] = {attribute, ch};
            buffered++;
        endfunction

        function void note_request(in_item_t req);
            int        n_prior;
            out_item_t r;
            n_prior = due_results.size();
            case (req.func)
                FUNC_WRITE:
                begin
                    if (buffered < BUFFER_DEPTH)
                    begin
                        buffer_char(req.char_code);
                        if (req.char_code == CH_NEWLINE)
                            drain_buffer();
                    end
                    else
                    begin
                        drain_buffer();
                        buffer_char(req.char_code);
                    end
                end
                FUNC_FLUSH:
                    drain_buffer();
                FUNC_CLEAR:
                begin
                    row = 0;
                    col = 0;
                    r = '0;
                    r.clear_all = 1'b1;
                    due_results.push_back(r);
                end
                default:
                    ;
            endcase
            if (due_results.size() > n_prior)
                due_results[due_results.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            if (errors < MAX_REPORTS)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                report($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                                 checked, name, want, got));
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: 0x%0h", got));
                return;
            end
            want = due_results.pop_front();
            compare("cell_write", want.cell_write, got.cell_write);
            compare("cell_address", want.cell_address, got.cell_address);
            compare("cell_data", want.cell_data, got.cell_data);
            compare("scroll_up", want.scroll_up, got.scroll_up);
            compare("clear_all", want.clear_all, got.clear_all);
            compare("cursor_position", want.cursor_position, got.cursor_position);
            compare("last", want.last, got.last);
            checked++;
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    in_item_t   item      = '0;
    logic       full;
    logic       empty;
    logic       pop       = 1'b0;
    out_item_t  result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    console_cell_checker sb;
    int send_idle_pct = 21;
    int recv_idle_pct = 71;
    int phase_items   = 0;
    int idle_cycles   = 0;

    text_console_cursor_engine_core #(
        .COLUMNS      (COLUMNS),
        .ROWS         (ROWS),
        .TAB_STEP     (TAB_STEP),
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.attribute = cfg_data;
            if (push && !full)
                sb.note_request(item);
            if (pop && !empty)
                sb.check_result(result);
            if ((cfg_valid && cfg_ready) || (push && !full) || (pop && !empty))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        if ($urandom_range(99) < 12)
            return CH_TAB;
        c = 8'($urandom_range(255));
        if (c == CH_NEWLINE)
            c = 8'h20;
        return c;
    endfunction

    task automatic send_request(logic [1:0] f, logic [7:0] c);
        in_item_t req;
        req.func      = f;
        req.char_code = c;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (full);
        if (f != FUNC_UNUSED)
            phase_items++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_sequence(seq_kind_t kind);
        int n;
        case (kind)
            SEQ_LINE:
            begin
                n = $urandom_range(0, 20);
                repeat (n) send_request(FUNC_WRITE, random_char());
                send_request(FUNC_WRITE, CH_NEWLINE);
            end
            SEQ_LONG:
            begin
                n = ($urandom_range(3) == 0) ? BUFFER_DEPTH : $urandom_range(65, 70);
                repeat (n) send_request(FUNC_WRITE, random_char());
                if ($urandom_range(1))
                    send_request(FUNC_WRITE, CH_NEWLINE);
                else
                    send_request(FUNC_FLUSH, 8'($urandom_range(255)));
            end
            SEQ_FLUSHED:
            begin
                n = $urandom_range(1, 12);
                repeat (n) send_request(FUNC_WRITE, random_char());
                send_request(FUNC_FLUSH, 8'($urandom_range(255)));
            end
            SEQ_CLEAR:
                send_request(FUNC_CLEAR, 8'($urandom_range(255)));
            SEQ_NOISE:
                send_request(FUNC_UNUSED, 8'($urandom_range(255)));
            SEQ_RAW:
                repeat ($urandom_range(1, 4))
                    send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
            SEQ_SCREEN:
                repeat (ROWS + 2)
                begin
                    repeat ($urandom_range(0, 2)) send_request(FUNC_WRITE, random_char());
                    send_request(FUNC_WRITE, CH_NEWLINE);
                end
            default:
                ;
        endcase
    endtask

    function automatic seq_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 55) return SEQ_LINE;
        if (r < 63) return SEQ_LONG;
        if (r < 75) return SEQ_FLUSHED;
        if (r < 79) return SEQ_CLEAR;
        if (r < 84) return SEQ_NOISE;
        return SEQ_RAW;
    endfunction

    task automatic run_phase(int s_pct, int r_pct, int quota, seq_kind_t opening);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        phase_items   = 0;
        run_sequence(opening);
        while (phase_items < quota)
            run_sequence(pick_kind());
        wait_idle();
    endtask

    task automatic directed_requests();
        send_request(FUNC_UNUSED, 8'hFF);
        send_request(FUNC_FLUSH, 8'h00);
        send_request(FUNC_CLEAR, 8'hFF);
        send_request(FUNC_WRITE, 8'h41);
        send_request(FUNC_WRITE, 8'h00);
        send_request(FUNC_WRITE, 8'hFF);
        send_request(FUNC_WRITE, 8'h7F);
        send_request(FUNC_WRITE, CH_NEWLINE);
        // tab stops across the row, the last one wraps
        repeat (COLUMNS / TAB_STEP) send_request(FUNC_WRITE, CH_TAB);
        send_request(FUNC_WRITE, 8'h78);
        send_request(FUNC_FLUSH, 8'hAA);
        send_request(FUNC_UNUSED, 8'h00);
        // clear keeps the buffered cell
        send_request(FUNC_WRITE, 8'h42);
        send_request(FUNC_CLEAR, 8'h00);
        send_request(FUNC_FLUSH, 8'h55);
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_requests();
        wait_idle();
        write_attribute(8'h00);
        run_phase(21, 71, 50, SEQ_LONG);
        write_attribute(8'hFF);
        run_phase(71, 21, 50, SEQ_SCREEN);
        write_attribute(8'($urandom_range(1, 254)));
        run_phase(0, 0, 20, SEQ_LINE);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
